@@ hdl/pqd_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette quantizer package
// Shared constants, types and arithmetic helpers of the palette quantizer.
// ----------------------------------------------------------------------------
package pqd_pkg;

    localparam int PALETTE_DEPTH_DEF = 64;
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT        = 1024;
    localparam int ROW_W             = 10;
    localparam int HGT_W             = 11;
    localparam int DIST_W            = 24;

    localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;

    localparam logic [7:0] SCALE_NORMAL = 8'd220;
    localparam logic [7:0] SCALE_DARK   = 8'd180;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [1:0] SHADE_DARK   = 2'd0;
    localparam logic [1:0] SHADE_NORMAL = 2'd1;
    localparam logic [1:0] SHADE_LIGHT  = 2'd2;

    localparam logic [1:0] SMODE_NORMAL = 2'd0;
    localparam logic [1:0] SMODE_TWO    = 2'd1;

    localparam logic [2:0] CFG_SHADE_MODE    = 3'd0;
    localparam logic [2:0] CFG_DITHER_ENABLE = 3'd1;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_PALETTE_COUNT = 3'd4;

    typedef logic [2:0][11:0]       chan12_t;
    typedef logic [2:0][7:0]        rgb_t;
    typedef logic [DIST_W-1:0]      dist_t;

    typedef struct packed {
        logic             valid;
        dist_t [2:0]      d;
    } dist_res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_PXL,
        S_SCAN,
        S_FETCH,
        S_UPD,
        S_DIFF,
        S_DRD,
        S_DWR,
        S_EMIT
    } state_t;

    function automatic logic signed [11:0] sat12(input logic signed [13:0] v);
        logic signed [11:0] r;
        if (v > 14'sd2047)
        begin
            r = 12'sd2047;
        end
        else if (v < -14'sd2048)
        begin
            r = -12'sd2048;
        end
        else
        begin
            r = v[11:0];
        end
        return r;
    endfunction

    // Exact floor(b * k / 255) for 8-bit operands.
    function automatic logic [7:0] scale255(input logic [7:0] b, input logic [7:0] k);
        logic [15:0] x;
        logic [16:0] q;
        x = 16'(b) * 16'(k);
        q = (17'(x) + 17'(x[15:8]) + 17'd1) >> 8;
        return q[7:0];
    endfunction

endpackage

@@ hdl/palette_quantizer_with_dither.sv @@
// ----------------------------------------------------------------------------
// Palette quantizer with error diffusion
// Maps raster-order pixels to the nearest shade of a loaded palette entry.
// ----------------------------------------------------------------------------
// The slave stream carries commands: load a palette entry, map a pixel, or
// read back the usage count of an entry. The master stream returns one
// transfer per pixel and per readback; a load returns nothing. The
// configuration channel is always ready; the user is to write it only while
// the block is idle, which the block itself does not enforce.
// A load completes in the idle state; a readback passes through S_COUNT. For a
// pixel, one palette entry is read from the palette memory per cycle into a
// two-stage distance pipeline, followed by the usage-count update and up to
// three read-modify-write passes on the row adjustment memory. One command is
// processed at a time.
// After reset all 2 * MAX_WIDTH entries of the row adjustment memory are
// cleared, one entry per cycle; no command is accepted during that pass.
// A transfer waits in the output register while the receiver stalls, and the
// next command is processed meanwhile; its result is held back until the
// output register has been taken.
// ----------------------------------------------------------------------------
module palette_quantizer_with_dither
#(
    parameter int PALETTE_DEPTH = pqd_pkg::PALETTE_DEPTH_DEF,
    parameter int MAX_WIDTH     = pqd_pkg::MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index, entry_id, red, green, blue, zero pad
    input  logic [47:0] s_axis_tdata,
    // op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chosen_id, chosen_shade, chosen_entry, usage_count, zero pad
    output logic [47:0] m_axis_tdata,
    // kind
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import pqd_pkg::*;

    localparam int PAW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int NW   = $clog2(PALETTE_DEPTH + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int ROWD = 2 * MAX_WIDTH;
    localparam int RAW  = $clog2(ROWD);

    function automatic logic [RAW-1:0] row_addr_f(input logic bank, input logic [CW-1:0] col);
        return bank ? (RAW'(MAX_WIDTH) + RAW'(col)) : RAW'(col);
    endfunction

    state_t state_reg, state_next;

    logic [1:0]        shade_mode_reg;
    logic              dither_reg;
    logic [10:0]       width_reg;
    logic [10:0]       height_reg;
    logic [6:0]        pcount_reg;

    logic [39:0]       pal_mem [PALETTE_DEPTH];
    logic [39:0]       pal_rdata_reg;
    logic [20:0]       cnt_mem [PALETTE_DEPTH];
    logic [20:0]       cnt_rdata_reg;
    logic              cnt_vld_reg [PALETTE_DEPTH];
    chan12_t           row_mem [ROWD];
    chan12_t           row_rdata_reg;

    logic [RAW-1:0]    clr_reg;
    logic [1:0]        op_reg;
    logic [5:0]        idx_reg;
    rgb_t              chan_reg;
    logic [CW-1:0]     column_pos_reg;
    logic [ROW_W-1:0]  row_pos_reg;
    logic [CW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;
    chan12_t           right_reg;
    chan12_t           px_reg;
    logic [NW-1:0]     iss_reg;
    logic              v0_reg, v1_reg, v2_reg;
    logic [PAW-1:0]    e0_reg, e1_reg, e2_reg;
    logic              have_reg;
    dist_t             best_d_reg;
    logic [PAW-1:0]    best_e_reg;
    logic [1:0]        best_shade_reg;
    logic [2:0][8:0]   err_reg;
    logic [1:0]        tgt_reg;

    logic              res_kind_reg;
    logic [15:0]       res_id_reg;
    logic [1:0]        res_shade_reg;
    logic [5:0]        res_entry_reg;
    logic [20:0]       res_count_reg;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [15:0]       out_id_reg;
    logic [1:0]        out_shade_reg;
    logic [5:0]        out_entry_reg;
    logic [20:0]       out_count_reg;

    logic [WW-1:0]     w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [NW-1:0]     n_eff;
    logic [CW-1:0]     col_c;
    logic [ROW_W-1:0]  row_c;
    logic [1:0]        tries;
    logic              col_more;
    logic              row_more;
    logic              in_xfer;
    logic              idx_ok;
    logic              scan_done;
    logic [CW-1:0]     tgt_col;

    logic              pal_we, pal_re, cnt_re, cnt_we, row_re, row_we;
    logic [PAW-1:0]    pal_waddr, pal_raddr, cnt_addr;
    logic [20:0]       cnt_wdata;
    logic [20:0]       cnt_cur;
    logic [RAW-1:0]    row_addr;
    chan12_t           row_wdata;
    chan12_t           px_next;
    chan12_t           dwr_data;
    chan12_t           right_next;
    logic [2:0][8:0]   err_next;
    logic [3:0]        wt;

    logic              b_have;
    dist_t             b_d;
    logic [PAW-1:0]    b_e;
    logic [1:0]        b_sh;
    logic [1:0]        shade_code [3];

    dist_res_t         dist_res;
    rgb_t              pal_base;

    assign shade_code[0] = SHADE_NORMAL;
    assign shade_code[1] = SHADE_LIGHT;
    assign shade_code[2] = SHADE_DARK;

    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign idx_ok        = 32'(idx_reg) < PALETTE_DEPTH;
    assign pal_base      = pal_rdata_reg[39:16];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {3'b0, out_count_reg, out_entry_reg, out_shade_reg, out_id_reg};

    // Effective image geometry and positions.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
        if (32'(pcount_reg) > PALETTE_DEPTH)
        begin
            n_eff = NW'(PALETTE_DEPTH);
        end
        else
        begin
            n_eff = NW'(pcount_reg);
        end
        col_c = (WW'(column_pos_reg) < w_eff) ? column_pos_reg : CW'(w_eff - WW'(1));
        row_c = (HGT_W'(row_pos_reg) < h_eff) ? row_pos_reg : ROW_W'(h_eff - HGT_W'(1));
        unique case (shade_mode_reg)
            SMODE_NORMAL: tries = 2'd1;
            SMODE_TWO:    tries = 2'd2;
            default:      tries = 2'd3;
        endcase
        col_more  = (WW'(col_reg) + WW'(1)) < w_eff;
        row_more  = (HGT_W'(row_reg) + HGT_W'(1)) < h_eff;
        scan_done = (iss_reg == n_eff) && !v0_reg && !v1_reg && !v2_reg;
        tgt_col   = CW'((CW + 1)'(col_reg) + (CW + 1)'(tgt_reg) - (CW + 1)'(1));
    end

    // Pixel arithmetic.
    always_comb
    begin
        logic signed [13:0] s14;
        logic signed [12:0] e13;
        logic signed [13:0] m;
        case (tgt_reg)
            2'd0:    wt = 4'd3;
            2'd1:    wt = 4'd5;
            default: wt = 4'd1;
        endcase
        for (int c = 0; c < 3; c++)
        begin
            s14 = $signed({6'b0, chan_reg[c]})
                + $signed({{2{right_reg[c][11]}}, right_reg[c]})
                + $signed({{2{row_rdata_reg[c][11]}}, row_rdata_reg[c]});
            px_next[c] = sat12(s14);
            e13 = $signed({px_reg[c][11], px_reg[c]}) - $signed({5'b0, pal_base[c]});
            err_next[c] = e13[12:4];
            m = 14'($signed(err_reg[c])) * 14'sd7;
            right_next[c] = sat12(m);
            m = 14'($signed(err_reg[c])) * $signed({10'b0, wt});
            dwr_data[c] = sat12($signed({{2{row_rdata_reg[c][11]}}, row_rdata_reg[c]}) + m);
        end
    end

    // Running minimum over the shades of the entry leaving the pipeline.
    always_comb
    begin
        b_have = have_reg;
        b_d    = best_d_reg;
        b_e    = best_e_reg;
        b_sh   = best_shade_reg;
        for (int s = 0; s < 3; s++)
        begin
            if (v2_reg && (s < int'(tries)) && (!b_have || (dist_res.d[s] < b_d)))
            begin
                b_have = 1'b1;
                b_d    = dist_res.d[s];
                b_e    = e2_reg;
                b_sh   = shade_code[s];
            end
        end
    end

    always_comb
    begin
        cnt_cur = cnt_vld_reg[best_e_reg] ? cnt_rdata_reg : '0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) == ROWD - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (s_axis_tuser)
                        OP_READ:  state_next = S_COUNT;
                        OP_PIXEL: state_next = S_PXL;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_COUNT: state_next = S_EMIT;
            S_PXL:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_UPD;
            S_UPD:   state_next = S_DIFF;
            S_DIFF:  state_next = (dither_reg && row_more) ? S_DRD : S_EMIT;
            S_DRD:   state_next = S_DWR;
            S_DWR:
            begin
                if ((tgt_reg == 2'd0) || ((tgt_reg == 2'd1) && col_more))
                begin
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb
    begin
        s_axis_tready = 1'b0;
        pal_we    = 1'b0;
        pal_waddr = PAW'(s_axis_tdata[5:0]);
        pal_re    = 1'b0;
        pal_raddr = PAW'(iss_reg);
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_addr  = best_e_reg;
        cnt_wdata = cnt_cur + 21'd1;
        row_re    = 1'b0;
        row_we    = 1'b0;
        row_addr  = row_addr_f(!row_reg[0], tgt_col);
        row_wdata = dwr_data;
        unique case (state_reg)
            S_CLEAR:
            begin
                row_we    = 1'b1;
                row_addr  = clr_reg;
                row_wdata = '0;
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cnt_addr      = PAW'(s_axis_tdata[5:0]);
                row_addr      = row_addr_f(row_c[0], col_c);
                if (in_xfer)
                begin
                    unique case (s_axis_tuser)
                        OP_LOAD:  pal_we = 32'(s_axis_tdata[5:0]) < PALETTE_DEPTH;
                        OP_READ:  cnt_re = 1'b1;
                        OP_PIXEL: row_re = 1'b1;
                        default:  pal_we = 1'b0;
                    endcase
                end
            end
            S_PXL:
            begin
                row_we    = 1'b1;
                row_addr  = row_addr_f(row_reg[0], col_reg);
                row_wdata = '0;
            end
            S_SCAN:
            begin
                pal_re = iss_reg < n_eff;
            end
            S_FETCH:
            begin
                pal_re    = 1'b1;
                pal_raddr = best_e_reg;
                cnt_re    = 1'b1;
            end
            S_UPD:
            begin
                cnt_we = cnt_cur < COUNT_MAX;
            end
            S_DRD:   row_re = 1'b1;
            S_DWR:   row_we = 1'b1;
            default: row_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[pal_waddr] <= s_axis_tdata[45:6];
        end
        if (pal_re)
        begin
            pal_rdata_reg <= pal_mem[pal_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_addr] <= row_wdata;
        end
        if (row_re)
        begin
            row_rdata_reg <= row_mem[row_addr];
        end
    end

    pqd_dist u_dist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v0_reg),
        .px       (px_reg),
        .base     (pal_base),
        .res      (dist_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            shade_mode_reg <= 2'd2;
            dither_reg     <= 1'b0;
            width_reg      <= 11'd128;
            height_reg     <= 11'd128;
            pcount_reg     <= 7'd1;
            clr_reg        <= '0;
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
            right_reg      <= '0;
            iss_reg        <= '0;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            have_reg       <= 1'b0;
            tgt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < PALETTE_DEPTH; i++)
            begin
                cnt_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SHADE_MODE:    shade_mode_reg <= cfg_data[1:0];
                    CFG_DITHER_ENABLE: dither_reg     <= cfg_data[0];
                    CFG_IMAGE_WIDTH:   width_reg      <= cfg_data;
                    CFG_IMAGE_HEIGHT:  height_reg     <= cfg_data;
                    CFG_PALETTE_COUNT: pcount_reg     <= cfg_data[6:0];
                    default:           pcount_reg     <= pcount_reg;
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + RAW'(1);
            end
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v0_reg <= (state_reg == S_SCAN) && pal_re;
            if (state_reg == S_PXL)
            begin
                right_reg <= '0;
                iss_reg   <= '0;
                have_reg  <= 1'b0;
            end
            if (state_reg == S_SCAN)
            begin
                have_reg <= b_have;
                if (pal_re)
                begin
                    iss_reg <= iss_reg + NW'(1);
                end
            end
            if (cnt_we)
            begin
                cnt_vld_reg[cnt_addr] <= 1'b1;
            end
            if (state_reg == S_DIFF)
            begin
                if (dither_reg && col_more)
                begin
                    right_reg <= right_next;
                end
                tgt_reg <= (col_reg != '0) ? 2'd0 : 2'd1;
                if (!col_more)
                begin
                    column_pos_reg <= '0;
                    row_pos_reg    <= row_more ? (row_reg + ROW_W'(1)) : '0;
                end
                else
                begin
                    column_pos_reg <= col_reg + CW'(1);
                    row_pos_reg    <= row_reg;
                end
            end
            if (state_reg == S_DWR)
            begin
                tgt_reg <= tgt_reg + 2'd1;
            end
            if (state_reg == S_EMIT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= PAW'(iss_reg);
        e1_reg <= e0_reg;
        e2_reg <= e1_reg;
        if (in_xfer)
        begin
            op_reg   <= s_axis_tuser;
            idx_reg  <= s_axis_tdata[5:0];
            chan_reg <= s_axis_tdata[45:22];
            col_reg  <= col_c;
            row_reg  <= row_c;
        end
        if (state_reg == S_PXL)
        begin
            px_reg         <= px_next;
            best_e_reg     <= '0;
            best_shade_reg <= SHADE_NORMAL;
        end
        if (state_reg == S_SCAN)
        begin
            best_d_reg     <= b_d;
            best_e_reg     <= b_e;
            best_shade_reg <= b_sh;
        end
        if (state_reg == S_COUNT)
        begin
            res_kind_reg  <= KIND_COUNT;
            res_id_reg    <= '0;
            res_shade_reg <= SHADE_DARK;
            res_entry_reg <= idx_reg;
            res_count_reg <= (idx_ok && (op_reg == OP_READ) && cnt_vld_reg[PAW'(idx_reg)])
                             ? cnt_rdata_reg : '0;
        end
        if (state_reg == S_UPD)
        begin
            err_reg       <= err_next;
            res_kind_reg  <= KIND_PIXEL;
            res_id_reg    <= pal_rdata_reg[15:0];
            res_shade_reg <= best_shade_reg;
            res_entry_reg <= 6'(best_e_reg);
            res_count_reg <= '0;
        end
        if (state_reg == S_EMIT && (!out_valid_reg || m_axis_tready))
        begin
            out_kind_reg  <= res_kind_reg;
            out_id_reg    <= res_id_reg;
            out_shade_reg <= res_shade_reg;
            out_entry_reg <= res_entry_reg;
            out_count_reg <= res_count_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("command accepted during the clearing pass");

    a_pipe_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dist_res.valid == v2_reg)
        else $error("distance pipeline out of step with entry tracking");

    a_shade_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_PIXEL)) |->
        (out_shade_reg == SHADE_DARK || out_shade_reg == SHADE_NORMAL
         || out_shade_reg == SHADE_LIGHT))
        else $error("invalid shade code in pixel result");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (iss_reg == n_eff))
        else $error("palette scan ended early");
`endif

endmodule

@@ hdl/pqd_dist.sv @@
// ----------------------------------------------------------------------------
// Palette quantizer distance pipeline
// Two-stage pipeline giving the squared distance of a pixel to the three
// shades of one palette entry, in the order normal, light, dark.
// ----------------------------------------------------------------------------
module pqd_dist
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pqd_pkg::chan12_t   px,
    input  pqd_pkg::rgb_t      base,
    output pqd_pkg::dist_res_t res
);
    import pqd_pkg::*;

    logic                     va_reg;
    logic                     vb_reg;
    logic signed [12:0]       diff_reg [3][3];
    logic signed [12:0]       diff_next [3][3];
    dist_t                    sum_reg [3];
    dist_t                    sum_next [3];

    always_comb
    begin
        logic [7:0] sv;
        for (int s = 0; s < 3; s++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                case (s)
                    0:       sv = scale255(base[c], SCALE_NORMAL);
                    1:       sv = base[c];
                    default: sv = scale255(base[c], SCALE_DARK);
                endcase
                diff_next[s][c] = $signed({px[c][11], px[c]}) - $signed({5'b0, sv});
            end
        end
    end

    always_comb
    begin
        logic signed [25:0] sq;
        for (int s = 0; s < 3; s++)
        begin
            sum_next[s] = '0;
            for (int c = 0; c < 3; c++)
            begin
                sq = diff_reg[s][c] * diff_reg[s][c];
                sum_next[s] = sum_next[s] + DIST_W'(sq[22:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sum_reg  <= sum_next;
    end

    assign res.valid = vb_reg;
    assign res.d[0]  = sum_reg[0];
    assign res.d[1]  = sum_reg[1];
    assign res.d[2]  = sum_reg[2];

endmodule

@@ dv/tb_palette_quantizer_with_dither.sv @@
// ----------------------------------------------------------------------------
// Palette quantizer testbench
// Loads a palette, streams pixels, usage readbacks and ignored commands through
// the block under several register settings and random handshake pressure, and
// checks every result transfer against a predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_palette_quantizer_with_dither;

    import pqd_pkg::*;

    typedef struct {
        logic        kind;
        logic [15:0] chosen_id;
        logic [1:0]  chosen_shade;
        logic [5:0]  chosen_entry;
        logic [20:0] usage_count;
    } quant_result_t;

    class quant_scoreboard;
        int unsigned shade_mode = 2;
        int unsigned dither_on = 0;
        int unsigned img_w = 128;
        int unsigned img_h = 128;
        int unsigned pal_n = 1;
        logic [15:0] pal_id [64];
        int          pal_rgb [64][3];
        int unsigned hits [64];
        int          row_err [2][1024][3];
        int          right_err [3];
        int unsigned col_pos = 0;
        int unsigned row_pos = 0;
        quant_result_t pending [$];
        int errors = 0;
        int pixels = 0;
        int reads = 0;

        function new();
            foreach (pal_id[i])
            begin
                pal_id[i] = '0;
                hits[i] = 0;
                for (int c = 0; c < 3; c++)
                begin
                    pal_rgb[i][c] = 0;
                end
            end
            foreach (row_err[b, x, c])
            begin
                row_err[b][x][c] = 0;
            end
            foreach (right_err[c])
            begin
                right_err[c] = 0;
            end
        endfunction

        function int clip12(int v);
            if (v > 2047)
            begin
                return 2047;
            end
            if (v < -2048)
            begin
                return -2048;
            end
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [10:0] val);
            case (idx)
                CFG_SHADE_MODE:    shade_mode = val & 3;
                CFG_DITHER_ENABLE: dither_on = val & 1;
                CFG_IMAGE_WIDTH:   img_w = val;
                CFG_IMAGE_HEIGHT:  img_h = val;
                CFG_PALETTE_COUNT: pal_n = val & 127;
                default: ;
            endcase
        endfunction

        function void note_input(logic [1:0] op, logic [5:0] idx, logic [15:0] id,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
            quant_result_t res;
            int px [3];
            int chan [3];
            int scales [3];
            logic [1:0] codes [3];
            int unsigned w, h, n, col, row, bank, tries, best_e;
            logic [1:0] best_shade;
            longint best_d, d, diff;
            bit have;
            int e3;
            chan[0] = r;
            chan[1] = g;
            chan[2] = b;
            scales = '{220, 255, 180};
            codes = '{SHADE_NORMAL, SHADE_LIGHT, SHADE_DARK};
            if (op == OP_LOAD)
            begin
                pal_id[idx] = id;
                for (int c = 0; c < 3; c++)
                begin
                    pal_rgb[idx][c] = chan[c];
                end
                return;
            end
            if (op == OP_READ)
            begin
                res = '{KIND_COUNT, 16'd0, 2'd0, idx, 21'(hits[idx])};
                pending.push_back(res);
                return;
            end
            if (op != OP_PIXEL)
            begin
                return;
            end
            w = (img_w == 0) ? 1 : ((img_w > 1024) ? 1024 : img_w);
            h = (img_h == 0) ? 1 : ((img_h > 1024) ? 1024 : img_h);
            n = (pal_n > 64) ? 64 : pal_n;
            col = (col_pos < w) ? col_pos : w - 1;
            row = (row_pos < h) ? row_pos : h - 1;
            bank = row & 1;
            for (int c = 0; c < 3; c++)
            begin
                px[c] = clip12(chan[c] + right_err[c] + row_err[bank][col][c]);
                right_err[c] = 0;
                row_err[bank][col][c] = 0;
            end
            tries = (shade_mode == 0) ? 1 : ((shade_mode == 1) ? 2 : 3);
            have = 0;
            best_e = 0;
            best_shade = SHADE_NORMAL;
            best_d = 0;
            for (int unsigned e = 0; e < n; e++)
            begin
                for (int s = 0; s < tries; s++)
                begin
                    d = 0;
                    for (int c = 0; c < 3; c++)
                    begin
                        diff = px[c] - (pal_rgb[e][c] * scales[s]) / 255;
                        d += diff * diff;
                    end
                    if (!have || d < best_d)
                    begin
                        have = 1;
                        best_d = d;
                        best_e = e;
                        best_shade = codes[s];
                    end
                end
            end
            if (hits[best_e] < 21'h1FFFFF)
            begin
                hits[best_e]++;
            end
            if (dither_on != 0)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    e3 = (px[c] - pal_rgb[best_e][c]) >>> 4;
                    if (col + 1 < w)
                    begin
                        right_err[c] = clip12(7 * e3);
                    end
                    if (row + 1 < h)
                    begin
                        if (col > 0)
                        begin
                            row_err[bank ^ 1][col - 1][c] =
                                clip12(row_err[bank ^ 1][col - 1][c] + 3 * e3);
                        end
                        row_err[bank ^ 1][col][c] = clip12(row_err[bank ^ 1][col][c] + 5 * e3);
                        if (col + 1 < w)
                        begin
                            row_err[bank ^ 1][col + 1][c] =
                                clip12(row_err[bank ^ 1][col + 1][c] + e3);
                        end
                    end
                end
            end
            if (col + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (row + 1 >= h) ? 0 : row + 1;
            end
            else
            begin
                col_pos = col + 1;
                row_pos = row;
            end
            res = '{KIND_PIXEL, pal_id[best_e], best_shade, 6'(best_e), 21'd0};
            pending.push_back(res);
        endfunction

        function void check_result(logic kind, logic [47:0] data);
            quant_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result transfer with nothing outstanding: kind %0d data %h", kind, data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (kind === KIND_PIXEL)
            begin
                pixels++;
            end
            else
            begin
                reads++;
            end
            if (kind !== exp_r.kind)
            begin
                $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                errors++;
            end
            if (data[15:0] !== exp_r.chosen_id)
            begin
                $error("chosen_id: expected %0d, got %0d", exp_r.chosen_id, data[15:0]);
                errors++;
            end
            if (data[17:16] !== exp_r.chosen_shade)
            begin
                $error("chosen_shade: expected %0d, got %0d", exp_r.chosen_shade, data[17:16]);
                errors++;
            end
            if (data[23:18] !== exp_r.chosen_entry)
            begin
                $error("chosen_entry: expected %0d, got %0d", exp_r.chosen_entry, data[23:18]);
                errors++;
            end
            if (data[44:24] !== exp_r.usage_count)
            begin
                $error("usage_count: expected %0d, got %0d", exp_r.usage_count, data[44:24]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    quant_scoreboard quant_sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int unsigned cycles = 0;

    palette_quantizer_with_dither dut (.*);

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("tb_palette_quantizer_with_dither failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            quant_sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    task automatic send_cmd(logic [1:0] op, logic [5:0] idx, logic [15:0] id,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, b, g, r, id, idx};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        quant_sb.note_input(op, idx, id, r, g, b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (quant_sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (120) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        quant_sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            send_cmd(OP_PIXEL, 6'($urandom), 16'($urandom), pick_level(), pick_level(),
                     pick_level());
        end
        else if (sel < 82)
        begin
            send_cmd(OP_LOAD, 6'($urandom), 16'($urandom), pick_level(), pick_level(),
                     pick_level());
        end
        else if (sel < 97)
        begin
            send_cmd(OP_READ, 6'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
        end
        else
        begin
            send_cmd(2'd3, 6'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
        end
    endtask

    int shade_set [8] = '{0, 1, 2, 3, 2, 1, 0, 2};
    int dith_set [8]  = '{1, 0, 1, 1, 0, 1, 1, 1};
    int width_set [8] = '{1, 3, 1024, 0, 2047, 5, 2, 7};
    int hgt_set [8]   = '{1, 4, 2, 2047, 0, 1024, 3, 6};
    int count_set [8] = '{64, 1, 0, 127, 7, 64, 33, 5};

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(OP_LOAD, 6'd0, 16'h0000, 8'd0, 8'd0, 8'd0);
        send_cmd(OP_LOAD, 6'd63, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        for (int i = 1; i < 63; i++)
        begin
            send_cmd(OP_LOAD, 6'(i), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_cmd(OP_PIXEL, 6'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(OP_PIXEL, 6'd0, 16'd0, 8'd255, 8'd255, 8'd255);
        send_cmd(OP_READ, 6'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(2'd3, 6'd63, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        send_cmd(OP_READ, 6'd63, 16'd0, 8'd0, 8'd0, 8'd0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 70;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cfg(CFG_SHADE_MODE, 11'(shade_set[ph]));
            write_cfg(CFG_DITHER_ENABLE, 11'(dith_set[ph]));
            write_cfg(CFG_IMAGE_WIDTH, 11'(width_set[ph]));
            write_cfg(CFG_IMAGE_HEIGHT, 11'(hgt_set[ph]));
            write_cfg(CFG_PALETTE_COUNT, 11'(count_set[ph]));
            for (int k = 0; k < 50; k++)
            begin
                random_cmd();
                if (ph == 2 && k == 25)
                begin
                    drain();
                end
            end
            drain();
        end

        $display("Covered %0d pixel results and %0d usage readbacks over 8 register settings.",
                 quant_sb.pixels, quant_sb.reads);
        if (quant_sb.errors == 0 && quant_sb.pending.size() == 0)
        begin
            $display("tb_palette_quantizer_with_dither passed");
        end
        else
        begin
            $display("tb_palette_quantizer_with_dither failed");
        end
        $finish;
    end

endmodule
